### rtl/firmware_image_record_loader_assert.svh
// assertion macros shared by the loader rtl
// expects signals named clk and rst_n in the including module
`ifndef FIRMWARE_IMAGE_RECORD_LOADER_ASSERT_SVH
`define FIRMWARE_IMAGE_RECORD_LOADER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/frl_pkg.sv
// shared types and constants of the firmware image record loader
// no dependencies
package frl_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int RECORD_BYTES = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] SIGNATURE_RESET = 32'hFACE_0001;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ERASE  = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_BADSIG = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_RECORD = 3'd1,
    PH_DATA   = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/frl_front.sv
// front stage: accepts raw bytes, inverts them and offers them to the queue
// depends on frl_pkg
module frl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_raw_byte,
  input  frl_pkg::q_status_t    q_status,
  output logic                  push,
  output logic [7:0]            push_byte
);
  import frl_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign push      = valid_r && !q_status.full;
  assign in_stall  = valid_r && q_status.full;
  assign push_byte = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored already inverted
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= ~in_raw_byte;
    end
  end

endmodule

### rtl/frl_queue.sv
// short byte queue between the front stage and the parser
// depends on frl_pkg and the assertion header
module frl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [7:0]         push_byte,
  input  logic               pop,
  output logic [7:0]         pop_byte,
  output frl_pkg::q_status_t status
);
  import frl_pkg::*;
  `include "firmware_image_record_loader_assert.svh"

  logic [7:0]        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_byte     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_byte;
    end
  end

  `FRL_ASSERT_NOW(a_no_push_full, status.full, !push, "push into full queue")
  `FRL_ASSERT_NOW(a_no_pop_empty, status.empty, !pop, "pop from empty queue")
  `FRL_ASSERT_NOW(a_count_range, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

### rtl/frl_back.sv
// back end: header and record parser with the signature register and result register
// depends on frl_pkg and the assertion header
module frl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  frl_pkg::q_status_t  q_status,
  input  logic [7:0]          pop_byte,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_action,
  output logic [31:0]         out_write_address,
  output logic [7:0]          out_write_data
);
  import frl_pkg::*;
  `include "firmware_image_record_loader_assert.svh"

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] sig_r;
  logic        ovalid_r, ovalid_nxt;
  action_t     act_r, act_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [7:0]  odata_r, odata_nxt;

  logic [31:0] word_sh;
  logic [31:0] hdr_word;
  logic        hdr_last;
  logic        rec_last;

  assign pop      = !q_status.empty && (!ovalid_r || !out_stall);
  assign word_sh  = {pop_byte, word_r[31:8]};
  assign hdr_word = (cnt_r < 4'd4) ? word_sh : word_r;
  assign hdr_last = ({1'b0, cnt_r} + 5'd1) >= 5'(HEADER_BYTES);
  assign rec_last = (cnt_r == 4'(RECORD_BYTES - 1));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_last) begin
            phase_nxt = (hdr_word != sig_r) ? PH_ERROR : PH_RECORD;
          end
        end
        PH_RECORD: begin
          if (rec_last) begin
            if (addr_r == '0) begin
              phase_nxt = PH_DONE;
            end else if (word_sh != '0) begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (rem_r == 32'd1) begin
            phase_nxt = PH_RECORD;
          end
        end
        PH_DONE, PH_ERROR: phase_nxt = phase_r;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    cnt_nxt    = cnt_r;
    word_nxt   = word_r;
    addr_nxt   = addr_r;
    rem_nxt    = rem_r;
    act_nxt    = act_r;
    oaddr_nxt  = oaddr_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && out_stall;
    if (pop) begin
      ovalid_nxt = 1'b1;
      act_nxt    = ACT_NONE;
      oaddr_nxt  = '0;
      odata_nxt  = '0;
      unique case (phase_r)
        PH_HEADER: begin
          word_nxt = hdr_word;
          if (hdr_last) begin
            cnt_nxt  = '0;
            word_nxt = '0;
            act_nxt  = (hdr_word != sig_r) ? ACT_BADSIG : ACT_ERASE;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        PH_RECORD: begin
          word_nxt = word_sh;
          if (cnt_r == 4'd3) begin
            addr_nxt = word_sh;
          end
          if (rec_last) begin
            cnt_nxt  = '0;
            word_nxt = '0;
            if (addr_r == '0) begin
              act_nxt = ACT_DONE;
            end else begin
              rem_nxt = word_sh;
            end
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        PH_DATA: begin
          act_nxt   = ACT_WRITE;
          oaddr_nxt = addr_r;
          odata_nxt = pop_byte;
          addr_nxt  = addr_r + 32'd1;
          rem_nxt   = rem_r - 32'd1;
        end
        PH_DONE, PH_ERROR: act_nxt = ACT_NONE;
        default: act_nxt = ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      word_r   <= '0;
      addr_r   <= '0;
      rem_r    <= '0;
      sig_r    <= SIGNATURE_RESET;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      word_r   <= word_nxt;
      addr_r   <= addr_nxt;
      rem_r    <= rem_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr_en) begin
        sig_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    oaddr_r <= oaddr_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_action        = act_r;
  assign out_write_address = oaddr_r;
  assign out_write_data    = odata_r;

  `FRL_ASSERT_NOW(a_data_has_bytes, phase_r == PH_DATA, rem_r != '0,
                  "data phase with no bytes left")
  `FRL_ASSERT_NEXT(a_done_sticky, phase_r == PH_DONE, phase_r == PH_DONE,
                   "left done phase")
  `FRL_ASSERT_NOW(a_pop_no_overwrite, ovalid_r && out_stall, !pop,
                  "result overwritten while stalled")

endmodule

### rtl/firmware_image_record_loader.sv
// top level of the firmware image record loader
// depends on frl_pkg, frl_front, frl_queue and frl_back
//
// takes one stored image byte per item, inverts it and parses a header of
// HEADER_BYTES bytes followed by 8-byte records (little-endian load address,
// little-endian length). every accepted item yields exactly one result item:
// none, erase all (good signature at the last header byte), bad signature,
// write byte (address and inverted data) or done (record with zero address).
// bytes after done or bad signature give action none until reset.
// throughput is one item per clock while out_stall is low. an item's result
// becomes valid after it has passed the front register, loaded at the accept,
// the four-entry queue and the parser's result register.
// the input stalls only when the queue is full; the parser takes a byte from
// the queue only while the result register is free or being taken.
// cfg_wr_data loads the signature register; write it only while idle.
module firmware_image_record_loader (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [31:0] out_write_address,
  output logic [7:0]  out_write_data
);
  import frl_pkg::*;

  q_status_t  q_status;
  logic       push;
  logic [7:0] push_byte;
  logic       pop;
  logic [7:0] pop_byte;

  // front: accept and invert
  frl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_byte (in_raw_byte),
    .q_status    (q_status),
    .push        (push),
    .push_byte   (push_byte)
  );

  // decoupling queue
  frl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_byte (push_byte),
    .pop       (pop),
    .pop_byte  (pop_byte),
    .status    (q_status)
  );

  // back: parser and result register
  frl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .q_status          (q_status),
    .pop_byte          (pop_byte),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

endmodule
